### hdl/i64da_pkg.sv
// ----------------------------------------------------------------------------
// i64da_pkg: shared types and constants
// Job word passed from the classifier to the converter, converter states and
// character codes.
// ----------------------------------------------------------------------------
package i64da_pkg;

	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 20;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);
	localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS - 1);

	// Magnitude to convert and whether a minus sign leads the text.
	typedef struct packed {
		logic [VALUE_W-1:0] mag;
		logic               neg;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} conv_state_t;

endpackage

### hdl/int64_to_decimal_ascii.sv
// Steps: a word is taken while the converter is idle and converted bit by bit; then a minus
// sign is sent if negative, leading zeros are skipped and the digits are sent in order.
// The converter takes a new value only once it has loaded the last character of the previous
// one; digits leave at one word per cycle while the output is not stalled.
// A two-entry job queue lets the input take new values while conversion runs.
// Reset: asynchronous, active low; clears the queue, converter state and output valid.
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii: 64-bit integer to decimal ASCII text
// Converts a 64-bit value, signed or unsigned, to its decimal text, most
// significant character first, one character per output word.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] raw_value
	input  logic        s_tuser,   // [0] opcode: 0 unsigned, 1 signed
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] text_char
	output logic        m_tlast    // last_char
);
	import i64da_pkg::*;

	localparam int JOB_W = $bits(job_t);

	logic             push_valid;
	logic             push_ready;
	job_t             push_job;
	logic             pop_valid;
	logic             pop_ready;
	logic [JOB_W-1:0] pop_bits;
	job_t             pop_job;

	assign pop_job = job_t'(pop_bits);

	i64da_front u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.raw_value   (s_tdata),
		.signed_mode (s_tuser),
		.job_valid   (push_valid),
		.job_ready   (push_ready),
		.job         (push_job)
	);

	i64da_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_bits)
	);

	i64da_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### hdl/i64da_fifo.sv
// ----------------------------------------------------------------------------
// i64da_fifo: small job queue
// Register-based queue between the classifier and the converter, so that
// either side can stall on its own. DEPTH must be at least 2.
// ----------------------------------------------------------------------------
module i64da_fifo #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/i64da_front.sv
// ----------------------------------------------------------------------------
// i64da_front: input classifier
// Decides the sign of each incoming word and forms its magnitude, so the
// converter only ever sees an unsigned value and a sign flag.
// ----------------------------------------------------------------------------
module i64da_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [i64da_pkg::VALUE_W-1:0] raw_value,
	input  logic                          signed_mode,
	output logic                          job_valid,
	input  logic                          job_ready,
	output i64da_pkg::job_t               job
);
	import i64da_pkg::*;

	logic negative;

	// The negation is done modulo 2^64, so the most negative value maps to
	// magnitude 2^63 without overflow.
	assign negative  = signed_mode && raw_value[VALUE_W-1];
	assign job.neg   = negative;
	assign job.mag   = negative ? (~raw_value + VALUE_W'(1)) : raw_value;
	assign job_valid = s_tvalid;
	assign s_tready  = job_ready;

endmodule

### hdl/i64da_back.sv
// ----------------------------------------------------------------------------
// i64da_back: bit-serial converter and character emitter
// Shift-and-add-3 binary to BCD over all 64 input bits, then leading-zero skip and
// one character per word out of a registered output stage.
// ----------------------------------------------------------------------------
module i64da_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  i64da_pkg::job_t job,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);
	import i64da_pkg::*;

	conv_state_t            state_q, state_d;
	logic [VALUE_W-1:0]     bin_q, bin_d;
	logic [BCD_W-1:0]       bcd_q, bcd_d;
	logic [BCD_W-1:0]       bcd_adj;
	logic                   neg_q, neg_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
	logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
	logic                   out_valid_q;
	logic [7:0]             out_char_q;
	logic                   out_last_q;
	logic                   out_free;
	logic                   out_load;
	logic [7:0]             out_char_d;
	logic                   out_last_d;
	logic [3:0]             top_digit;

	assign out_free  = !out_valid_q || m_tready;
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_char_q;
	assign m_tlast   = out_last_q;

	// Each BCD digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		state_d    = state_q;
		bin_d      = bin_q;
		bcd_d      = bcd_q;
		neg_d      = neg_q;
		bit_cnt_d  = bit_cnt_q;
		dig_cnt_d  = dig_cnt_q;
		job_ready  = 1'b0;
		out_load   = 1'b0;
		out_char_d = CHAR_ZERO + {4'd0, top_digit};
		out_last_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					bin_d     = job.mag;
					neg_d     = job.neg;
					bcd_d     = '0;
					bit_cnt_d = '0;
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				bcd_d     = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
				bin_d     = {bin_q[VALUE_W-2:0], 1'b0};
				bit_cnt_d = bit_cnt_q + 1'b1;
				if (bit_cnt_q == LAST_BIT) begin
					dig_cnt_d = '0;
					state_d   = neg_q ? ST_SIGN : ST_SKIP;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_char_d = CHAR_MINUS;
					state_d    = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// The lowest digit is always sent, so zero still gives one character.
				if (top_digit == 4'd0 && dig_cnt_q != LAST_DIGIT) begin
					bcd_d     = {bcd_q[BCD_W-5:0], 4'd0};
					dig_cnt_d = dig_cnt_q + 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = (dig_cnt_q == LAST_DIGIT);
					bcd_d      = {bcd_q[BCD_W-5:0], 4'd0};
					dig_cnt_d  = dig_cnt_q + 1'b1;
					if (dig_cnt_q == LAST_DIGIT) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		bin_q     <= bin_d;
		bcd_q     <= bcd_d;
		neg_q     <= neg_d;
		bit_cnt_q <= bit_cnt_d;
		dig_cnt_q <= dig_cnt_d;
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
		end
	end

endmodule

### tb/tb_int64_to_decimal_ascii.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int64_to_decimal_ascii: testbench for the 64-bit decimal text converter
// Sends values in both modes through the input stream and predicts their
// decimal text one character at a time. Every character word on the output
// stream is checked against the oldest predicted character, while both
// stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_int64_to_decimal_ascii;
	import i64da_pkg::*;

	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED   = 1'b1;
	localparam int   IDLE_LIMIT    = 5000;
	localparam int   MAX_REPORTS   = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	text_char_t pending_chars[$];
	int         mismatches;
	int         values_sent;
	int         negatives_sent;
	int         chars_checked;
	int         idle_cycles;
	bit         ready_always;

	int64_to_decimal_ascii i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Decimal text of one value, most significant character first.
	function automatic void predict_text(logic [63:0] raw, logic mode);
		logic [7:0] digits [NUM_DIGITS];
		logic [63:0] mag;
		logic        neg;
		int          nd;
		text_char_t  c;
		neg = (mode == MODE_SIGNED) && raw[63];
		// Two's complement negation in unsigned arithmetic also covers the
		// most negative value, whose magnitude is 2^63.
		mag = neg ? (~raw + 64'd1) : raw;
		nd = 0;
		do begin
			digits[nd] = CHAR_ZERO + 8'(mag % 64'd10);
			nd++;
			mag = mag / 64'd10;
		end while (mag != 64'd0 && nd < NUM_DIGITS);
		if (neg) begin
			c.ch = CHAR_MINUS;
			c.last = 1'b0;
			pending_chars.push_back(c);
			negatives_sent++;
		end
		while (nd > 0) begin
			nd--;
			c.ch = digits[nd];
			c.last = (nd == 0);
			pending_chars.push_back(c);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		else if (r < 17)
			return $urandom_range(1, 4);
		else
			return $urandom_range(20, 150);
	endfunction

	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		logic [63:0] p;
		int          kind;
		int          k;
		kind = $urandom_range(0, 9);
		v = {$urandom, $urandom};
		if (kind < 4) begin
			// Full width: every bit is exercised.
		end else if (kind < 7) begin
			k = $urandom_range(1, 63);
			v = v & ((64'd1 << k) - 64'd1);
		end else if (kind < 9) begin
			// Around a power of ten, where the digit count changes.
			p = 64'd1;
			k = $urandom_range(0, 19);
			repeat (k) p = p * 64'd10;
			v = $urandom_range(0, 1) ? p - 64'($urandom_range(0, 2))
			                         : p + 64'($urandom_range(0, 2));
			if ($urandom_range(0, 3) == 0)
				v = ~v + 64'd1;
		end else begin
			case ($urandom_range(0, 3))
				0: v = 64'hFFFF_FFFF_FFFF_FFFF;
				1: v = 64'h8000_0000_0000_0000;
				2: v = 64'h7FFF_FFFF_FFFF_FFFF;
				default: v = 64'($urandom_range(0, 9));
			endcase
		end
		return v;
	endfunction

	// Offers one value word, waits for it to be taken, then idles for gap cycles.
	task automatic send_value(logic [63:0] raw, logic mode, int gap);
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		predict_text(raw, mode);
		values_sent++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, $urandom};
			s_tuser  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [63:0] dir_vals [12];
		dir_vals = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99,
		             64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
		             64'h7FFF_FFFF_FFFF_FFFF, 64'd10_000_000_000_000_000_000,
		             64'd9_999_999_999_999_999_999, 64'hFFFF_FFFF_FFFF_FFF6,
		             64'h8000_0000_0000_0001};
		foreach (dir_vals[i]) begin
			send_value(dir_vals[i], MODE_UNSIGNED, pick_gap());
			send_value(dir_vals[i], MODE_SIGNED, pick_gap());
		end
	endtask

	task automatic test_random_values();
		for (int i = 0; i < 140; i++) begin
			if (i == 70) begin
				// Let the converter run dry before carrying on.
				send_value(pick_value(), 1'($urandom), 1);
				wait_drained();
			end else begin
				send_value(pick_value(), 1'($urandom), pick_gap());
			end
		end
	endtask

	task automatic test_back_to_back();
		ready_always = 1'b1;
		for (int i = 0; i < 12; i++)
			send_value(pick_value(), 1'($urandom), 0);
		s_tvalid <= 1'b0;
		wait_drained();
		ready_always = 1'b0;
	endtask

	// Output side stalls: stretches of full rate, random gaps and long holds.
	initial begin
		int n;
		int kind;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 40);
			kind = $urandom_range(0, 9);
			repeat (n) begin
				@(posedge clk);
				if (ready_always || kind < 4)
					m_tready <= 1'b1;
				else if (kind < 8)
					m_tready <= ($urandom_range(0, 3) != 0);
				else
					m_tready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected character word: char %h last %b",
					         m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.ch || m_tlast !== want.last) begin
					if (mismatches < MAX_REPORTS)
						$display("mismatch: expected char %h last %b, got char %h last %b",
						         want.ch, want.last, m_tdata, m_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d characters outstanding",
			         idle_cycles, pending_chars.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		mismatches     = 0;
		values_sent    = 0;
		negatives_sent = 0;
		chars_checked  = 0;
		idle_cycles    = 0;
		ready_always   = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 64'd0;
		s_tuser  = MODE_UNSIGNED;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_values();
		test_back_to_back();

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (150) @(posedge clk);

		$display("Converted %0d values (%0d negative in signed mode), checked %0d characters.",
		         values_sent, negatives_sent, chars_checked);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0 && pending_chars.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
